[rtl/core/orsp_pkg.sv]
package orsp_pkg;

	// Defaults for the top-level parameters.
	localparam int CAPACITY_DEF = 32;
	localparam int COORD_WIDTH_DEF = 16;

	// Width of the source buffer identifier.
	localparam int ID_WIDTH = 16;

	// Number of pieces around an intersection (center excluded).
	localparam int NUM_PIECES = 8;

	// Column and row of each piece, in the order TL, L, BL, T, B, TR, R, BR.
	localparam logic [1:0] PIECE_COL [NUM_PIECES] = '{
		2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
	localparam logic [1:0] PIECE_ROW [NUM_PIECES] = '{
		2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};

	// Status of the request queue between front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/core/orsp_queue.sv]
module orsp_queue #(
	parameter int DW = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [DW-1:0]          push_data,
	input  logic                   pop,
	output logic [DW-1:0]          head_data,
	output orsp_pkg::q_status_t    status
);
	import orsp_pkg::*;

	logic [DW-1:0] slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	// Two-entry queue of pending requests.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Payload slots need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_data    = slot_q[rd_ptr_q];
	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);

endmodule

[rtl/core/orsp_front.sv]
module orsp_front #(
	parameter int COORD_WIDTH = orsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_ready,
	input  logic signed [COORD_WIDTH-1:0]                dest_left,
	input  logic signed [COORD_WIDTH-1:0]                dest_top,
	input  logic signed [COORD_WIDTH-1:0]                dest_right,
	input  logic signed [COORD_WIDTH-1:0]                dest_bottom,
	input  logic signed [COORD_WIDTH-1:0]                src_x,
	input  logic signed [COORD_WIDTH-1:0]                src_y,
	input  logic [orsp_pkg::ID_WIDTH-1:0]                source_id,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic                                         cfg_enable,
	input  orsp_pkg::q_status_t                          q_status,
	output logic                                         q_push,
	output logic [6*COORD_WIDTH+orsp_pkg::ID_WIDTH:0]    q_data
);
	import orsp_pkg::*;

	logic enable_q;

	// Enable register; writes are always taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid) begin
			enable_q <= cfg_enable;
		end
	end

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_status.full;
	assign q_push    = in_valid && in_ready;

	// Each request is tagged with the enable state it was accepted under.
	assign q_data = {enable_q, source_id, src_y, src_x,
		dest_bottom, dest_right, dest_top, dest_left};

endmodule

[rtl/core/orsp_back.sv]
module orsp_back #(
	parameter int CAPACITY    = orsp_pkg::CAPACITY_DEF,
	parameter int COORD_WIDTH = orsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  orsp_pkg::q_status_t                       q_status,
	input  logic [6*COORD_WIDTH+orsp_pkg::ID_WIDTH:0] q_data,
	output logic                                      q_pop,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic signed [COORD_WIDTH-1:0]             out_left,
	output logic signed [COORD_WIDTH-1:0]             out_top,
	output logic signed [COORD_WIDTH-1:0]             out_right,
	output logic signed [COORD_WIDTH-1:0]             out_bottom,
	output logic signed [COORD_WIDTH-1:0]             out_src_x,
	output logic signed [COORD_WIDTH-1:0]             out_src_y,
	output logic [orsp_pkg::ID_WIDTH-1:0]             out_source_id,
	output logic                                      last,
	output logic                                      accepted,
	output logic                                      overflow
);
	import orsp_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int EW = 6 * W + ID_WIDTH;
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] LIMIT = CW'(CAPACITY - 1);
	localparam logic [CW-1:0] ONE   = CW'(1);

	typedef enum logic [2:0] {
		S_IDLE, S_FETCH, S_EVAL, S_SPLIT, S_APPEND, S_EFETCH, S_ELOAD
	} state_t;

	state_t        state_q;
	logic          bank_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic [2:0]    pc_q;

	logic [EW-1:0] mem [2][CAPACITY];
	logic [EW-1:0] rd_data_q;

	logic signed [W-1:0] xs_q [4];
	logic signed [W-1:0] ys_q [4];
	logic signed [W-1:0] esx_q, esy_q;
	logic [ID_WIDTH-1:0] eid_q;

	// Request fields.
	logic signed [W-1:0] nl, nt, nr, nb;
	logic                nen;
	assign nl  = q_data[W-1:0];
	assign nt  = q_data[2*W-1:W];
	assign nr  = q_data[3*W-1:2*W];
	assign nb  = q_data[4*W-1:3*W];
	assign nen = q_data[EW];

	// Fields of the old entry under evaluation.
	logic signed [W-1:0] el, et, er, eb, esx, esy;
	logic [ID_WIDTH-1:0] eid;
	assign el  = rd_data_q[W-1:0];
	assign et  = rd_data_q[2*W-1:W];
	assign er  = rd_data_q[3*W-1:2*W];
	assign eb  = rd_data_q[4*W-1:3*W];
	assign esx = rd_data_q[5*W-1:4*W];
	assign esy = rd_data_q[6*W-1:5*W];
	assign eid = rd_data_q[EW-1:6*W];

	// Overlap and full-cover tests, and the intersection edges.
	logic overlap, covered;
	logic signed [W-1:0] il, it, ir, ib;
	assign overlap = (el < nr) && (nl < er) && (et < nb) && (nt < eb);
	assign covered = (nl <= el) && (nt <= et) && (nr >= er) && (nb >= eb);
	assign il = (el > nl) ? el : nl;
	assign it = (et > nt) ? et : nt;
	assign ir = (er < nr) ? er : nr;
	assign ib = (eb < nb) ? eb : nb;

	// Current piece: its edges, source offset and whether it is nonempty.
	logic [1:0]          pcol, prow;
	logic signed [W-1:0] px0, px1, py0, py1, psx, psy;
	logic                piece_ok;
	always_comb begin
		pcol = PIECE_COL[pc_q];
		prow = PIECE_ROW[pc_q];
		px0  = xs_q[pcol];
		px1  = xs_q[pcol + 2'd1];
		py0  = ys_q[prow];
		py1  = ys_q[prow + 2'd1];
		psx  = esx_q + (px0 - xs_q[0]);
		psy  = esy_q + (py0 - ys_q[0]);
		piece_ok = (px1 != px0) && (py1 != py0);
	end

	logic room, last_old, last_emit, out_free;
	assign room      = (n_q < LIMIT);
	assign last_old  = ((idx_q + ONE) == cnt_q);
	assign last_emit = ((idx_q + ONE) == cnt_q);
	assign out_free  = !out_valid || out_ready;

	// A result beat is loaded into the output register this cycle.
	logic emit;
	assign emit = ((state_q == S_IDLE) && !q_status.empty && !nen && out_free)
		|| ((state_q == S_ELOAD) && out_free);

	// Write port into the bank being built.
	logic          we;
	logic [EW-1:0] wdata;
	always_comb begin
		we    = 1'b0;
		wdata = rd_data_q;
		unique case (state_q)
			S_EVAL: begin
				we = !overlap && room;
			end
			S_SPLIT: begin
				we    = piece_ok && room;
				wdata = {eid_q, psy, psx, py1, px1, py0, px0};
			end
			S_APPEND: begin
				we    = 1'b1;
				wdata = q_data[EW-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// List storage, two banks: reads from the current one, writes to the other.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[~bank_q][n_q[IW-1:0]] <= wdata;
		end
		rd_data_q <= mem[bank_q][idx_q[IW-1:0]];
	end

	assign q_pop = ((state_q == S_IDLE) && !q_status.empty && !nen && out_free)
		|| ((state_q == S_ELOAD) && out_free && last_emit);

	// Sequencer: walk the old list, split, append, then emit the new list; a disabled request emits one refused beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			bank_q    <= 1'b0;
			cnt_q     <= '0;
			idx_q     <= '0;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			pc_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_status.empty) begin
						if (!nen) begin
							if (out_free) begin
								out_left      <= '0;
								out_top       <= '0;
								out_right     <= '0;
								out_bottom    <= '0;
								out_src_x     <= '0;
								out_src_y     <= '0;
								out_source_id <= '0;
								last          <= 1'b1;
								accepted      <= 1'b0;
								overflow      <= 1'b0;
							end
						end else begin
							idx_q   <= '0;
							n_q     <= '0;
							ovf_q   <= 1'b0;
							state_q <= (cnt_q == '0) ? S_APPEND : S_FETCH;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (!overlap) begin
						if (room) begin
							n_q <= n_q + ONE;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					if (overlap && !covered) begin
						xs_q[0] <= el; xs_q[1] <= il; xs_q[2] <= ir; xs_q[3] <= er;
						ys_q[0] <= et; ys_q[1] <= it; ys_q[2] <= ib; ys_q[3] <= eb;
						esx_q   <= esx;
						esy_q   <= esy;
						eid_q   <= eid;
						pc_q    <= '0;
						state_q <= S_SPLIT;
					end else begin
						idx_q   <= idx_q + ONE;
						state_q <= last_old ? S_APPEND : S_FETCH;
					end
				end
				S_SPLIT: begin
					if (piece_ok) begin
						if (room) begin
							n_q <= n_q + ONE;
						end else begin
							ovf_q <= 1'b1;
						end
					end
					pc_q <= pc_q + 3'd1;
					if (pc_q == 3'(NUM_PIECES - 1)) begin
						idx_q   <= idx_q + ONE;
						state_q <= last_old ? S_APPEND : S_FETCH;
					end
				end
				S_APPEND: begin
					cnt_q   <= n_q + ONE;
					bank_q  <= ~bank_q;
					idx_q   <= '0;
					state_q <= S_EFETCH;
				end
				S_EFETCH: begin
					state_q <= S_ELOAD;
				end
				S_ELOAD: begin
					if (out_free) begin
						out_left      <= el;
						out_top       <= et;
						out_right     <= er;
						out_bottom    <= eb;
						out_src_x     <= esx;
						out_src_y     <= esy;
						out_source_id <= eid;
						last          <= last_emit;
						accepted      <= 1'b1;
						overflow      <= ovf_q;
						idx_q         <= idx_q + ONE;
						state_q       <= last_emit ? S_IDLE : S_EFETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/occlusion_rect_splitter.sv]
// Visible-rectangle list for painter's-order compositing.
// Input channel (in_valid/in_ready): one request per new top-most rectangle
// with its source offset and source buffer id. Output channel
// (out_valid/out_ready): the whole new list, one entry per beat, with last
// on the final entry and overflow on every entry if fragments were dropped.
// When disabled, a request yields a single beat with accepted low.
// Configuration channel (cfg_valid/cfg_ready, cfg_enable) is always ready;
// write it only while no request is in flight.
// A two-entry request queue lets the input side run ahead of the list walk.
// Per request, with N old entries and M new ones, the sequencer walks the
// N old entries, splitting each partly covered one into its nonempty pieces,
// then emits the M new entries; the list memory gives one entry per cycle
// and is read once per old entry and once per emitted entry. A disabled
// request is answered from the idle state without a list walk; a stalled
// receiver holds the sequencer in its emit step.
// Reset empties the list and sets enable to one.
module occlusion_rect_splitter #(
	parameter int CAPACITY    = orsp_pkg::CAPACITY_DEF,
	parameter int COORD_WIDTH = orsp_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     dest_left,
	input  logic signed [COORD_WIDTH-1:0]     dest_top,
	input  logic signed [COORD_WIDTH-1:0]     dest_right,
	input  logic signed [COORD_WIDTH-1:0]     dest_bottom,
	input  logic signed [COORD_WIDTH-1:0]     src_x,
	input  logic signed [COORD_WIDTH-1:0]     src_y,
	input  logic [orsp_pkg::ID_WIDTH-1:0]     source_id,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_enable,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COORD_WIDTH-1:0]     out_left,
	output logic signed [COORD_WIDTH-1:0]     out_top,
	output logic signed [COORD_WIDTH-1:0]     out_right,
	output logic signed [COORD_WIDTH-1:0]     out_bottom,
	output logic signed [COORD_WIDTH-1:0]     out_src_x,
	output logic signed [COORD_WIDTH-1:0]     out_src_y,
	output logic [orsp_pkg::ID_WIDTH-1:0]     out_source_id,
	output logic                              last,
	output logic                              accepted,
	output logic                              overflow
);
	import orsp_pkg::*;

	localparam int DW = 6 * COORD_WIDTH + ID_WIDTH + 1;

	q_status_t     q_status;
	logic          q_push;
	logic          q_pop;
	logic [DW-1:0] q_in;
	logic [DW-1:0] q_head;

	// Front: takes requests and configuration.
	orsp_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.dest_left, .dest_top, .dest_right, .dest_bottom,
		.src_x, .src_y, .source_id,
		.cfg_valid, .cfg_ready, .cfg_enable,
		.q_status, .q_push, .q_data(q_in)
	);

	// Queue between front and back.
	orsp_queue #(.DW(DW)) u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_in),
		.pop(q_pop), .head_data(q_head), .status(q_status)
	);

	// Back: walks, splits and emits the list.
	orsp_back #(.CAPACITY(CAPACITY), .COORD_WIDTH(COORD_WIDTH)) u_back (
		.clk, .arst_n, .q_status, .q_data(q_head), .q_pop,
		.out_valid, .out_ready,
		.out_left, .out_top, .out_right, .out_bottom,
		.out_src_x, .out_src_y, .out_source_id,
		.last, .accepted, .overflow
	);

endmodule

[rtl/core/orsp_checker.sv]
module orsp_checker #(
	parameter int COORD_WIDTH = orsp_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [COORD_WIDTH-1:0]        out_left,
	input logic [COORD_WIDTH-1:0]        out_right,
	input logic [orsp_pkg::ID_WIDTH-1:0] out_source_id,
	input logic                          last,
	input logic                          accepted,
	input logic                          overflow
);
	import orsp_pkg::*;

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(last))
		else $error("stalled result changed");

	// A refused request is a single final beat.
	a_refused_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> last)
		else $error("refused result not marked last");

	// A refused request carries zero fields and no overflow.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> out_left == '0 && out_right == '0
			&& out_source_id == '0 && !overflow)
		else $error("refused result not zero");

	// Overflow stays the same across the beats of one list.
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last ##1 out_valid |-> overflow == $past(overflow))
		else $error("overflow changed within a list");

endmodule

bind occlusion_rect_splitter orsp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_orsp_checker (.*);

[test/rect_list_checker.sv]
module rect_list_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [15:0] dest_left,
	input  logic [15:0] dest_top,
	input  logic [15:0] dest_right,
	input  logic [15:0] dest_bottom,
	input  logic [15:0] src_x,
	input  logic [15:0] src_y,
	input  logic [15:0] source_id,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_enable,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_left,
	input  logic [15:0] out_top,
	input  logic [15:0] out_right,
	input  logic [15:0] out_bottom,
	input  logic [15:0] out_src_x,
	input  logic [15:0] out_src_y,
	input  logic [15:0] out_source_id,
	input  logic        last,
	input  logic        accepted,
	input  logic        overflow,
	output int          fail_count,
	output int          pending_entries
);

	localparam int LIST_CAP = 32;

	typedef struct packed {
		logic signed [15:0] l;
		logic signed [15:0] t;
		logic signed [15:0] r;
		logic signed [15:0] b;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [15:0]        id;
	} vis_rect_t;

	typedef struct packed {
		vis_rect_t rect;
		logic      last;
		logic      accepted;
		logic      overflow;
	} list_beat_t;

	vis_rect_t    visible_list[$];
	list_beat_t   expected_beats[$];
	logic         render_on;

	// Print one line for a mismatch and count it.
	task automatic report_mismatch(input string what);
		$display("mismatch: %s at %0t", what, $time);
		fail_count++;
	endtask

	// Add a piece to the new list unless the capacity for old pieces is used up.
	task automatic add_piece(inout vis_rect_t nl[$], inout logic ovf, input vis_rect_t p);
		if (nl.size() >= LIST_CAP - 1)
			ovf = 1'b1;
		else
			nl = {nl, p};
	endtask

	// Place a new top-most rectangle and queue the whole emitted list.
	task automatic place_rect(input vis_rect_t n);
		vis_rect_t    nl[$];
		vis_rect_t    o, p;
		logic         ovf;
		logic signed [15:0] xs[4], ys[4];
		list_beat_t   bt;

		ovf = 1'b0;
		if (!render_on) begin
			bt = '0;
			bt.last = 1'b1;
			expected_beats = {expected_beats, bt};
			return;
		end
		foreach (visible_list[i]) begin
			o = visible_list[i];
			if (!(o.l < n.r && n.l < o.r && o.t < n.b && n.t < o.b)) begin
				add_piece(nl, ovf, o);
				continue;
			end
			if (n.l <= o.l && n.t <= o.t && n.r >= o.r && n.b >= o.b)
				continue;
			xs[0] = o.l; xs[1] = (o.l > n.l) ? o.l : n.l;
			xs[2] = (o.r < n.r) ? o.r : n.r; xs[3] = o.r;
			ys[0] = o.t; ys[1] = (o.t > n.t) ? o.t : n.t;
			ys[2] = (o.b < n.b) ? o.b : n.b; ys[3] = o.b;
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					if (c == 1 && r == 1)
						continue;
					if (xs[c+1] == xs[c] || ys[r+1] == ys[r])
						continue;
					p.l = xs[c]; p.t = ys[r]; p.r = xs[c+1]; p.b = ys[r+1];
					p.sx = o.sx + (xs[c] - xs[0]);
					p.sy = o.sy + (ys[r] - ys[0]);
					p.id = o.id;
					add_piece(nl, ovf, p);
				end
			end
		end
		nl = {nl, n};
		visible_list = nl;
		foreach (nl[k]) begin
			bt.rect = nl[k];
			bt.last = (k == nl.size() - 1);
			bt.accepted = 1'b1;
			bt.overflow = ovf;
			expected_beats = {expected_beats, bt};
		end
	endtask

	// Watch all three channels at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		vis_rect_t  n;
		list_beat_t e;
		if (!arst_n) begin
			visible_list.delete();
			expected_beats.delete();
			render_on = 1'b1;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				render_on = cfg_enable;
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected list entry");
				end else begin
					e = expected_beats.pop_front();
					if (out_left !== e.rect.l) report_mismatch("out_left");
					if (out_top !== e.rect.t) report_mismatch("out_top");
					if (out_right !== e.rect.r) report_mismatch("out_right");
					if (out_bottom !== e.rect.b) report_mismatch("out_bottom");
					if (out_src_x !== e.rect.sx) report_mismatch("out_src_x");
					if (out_src_y !== e.rect.sy) report_mismatch("out_src_y");
					if (out_source_id !== e.rect.id) report_mismatch("out_source_id");
					if (last !== e.last) report_mismatch("last");
					if (accepted !== e.accepted) report_mismatch("accepted");
					if (overflow !== e.overflow) report_mismatch("overflow");
				end
			end
			if (in_valid && in_ready) begin
				n.l = dest_left; n.t = dest_top; n.r = dest_right; n.b = dest_bottom;
				n.sx = src_x; n.sy = src_y; n.id = source_id;
				place_rect(n);
			end
		end
		pending_entries = expected_beats.size();
	end

endmodule

[test/testbench.sv]
module testbench;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	logic [15:0] dest_left, dest_top, dest_right, dest_bottom;
	logic [15:0] src_x, src_y, source_id;
	logic        cfg_valid, cfg_ready, cfg_enable;
	logic        out_valid, out_ready;
	logic [15:0] out_left, out_top, out_right, out_bottom;
	logic [15:0] out_src_x, out_src_y, out_source_id;
	logic        last, accepted, overflow;
	int          fail_count, pending_entries;
	int          idle_cycles;
	logic        calm_phase;

	localparam int WATCHDOG_LIMIT = 20000;

	occlusion_rect_splitter dut (.*);
	rect_list_checker chk (.*);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles in which no request or list entry moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver stalls in short bursts until the calm phase.
	initial begin
		int hold;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!calm_phase && $urandom_range(5) == 0) begin
				hold = $urandom_range(2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Send one rectangle request, with an occasional short gap before it.
	// Valid stays high after acceptance until the next request or an idle step.
	task automatic send_rect(input logic [15:0] l, t, r, b, sx, sy, id);
		if (!calm_phase && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		dest_left <= l; dest_top <= t; dest_right <= r; dest_bottom <= b;
		src_x <= sx; src_y <= sy; source_id <= id;
		@(posedge clk iff in_ready);
	endtask

	// Write the enable register once the block has drained.
	task automatic set_enable(input logic en);
		in_valid <= 1'b0;
		while (pending_entries != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_enable <= en;
		@(posedge clk iff cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random rectangle, mostly small and near the origin so entries overlap.
	task automatic send_random();
		logic [15:0] l, t;
		if ($urandom_range(9) == 0) begin
			send_rect(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
		end else begin
			l = 16'($urandom_range(0, 60)) - 16'd30;
			t = 16'($urandom_range(0, 60)) - 16'd30;
			send_rect(l, t, l + 16'($urandom_range(0, 40)), t + 16'($urandom_range(0, 40)),
				16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		in_valid = 1'b0; cfg_valid = 1'b0; cfg_enable = 1'b1;
		dest_left = '0; dest_top = '0; dest_right = '0; dest_bottom = '0;
		src_x = '0; src_y = '0; source_id = '0;
		calm_phase = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a split in all eight directions, a full cover, no overlap.
		send_rect(0, 0, 30, 30, 100, 200, 16'h0001);
		send_rect(10, 10, 20, 20, 5, 6, 16'h0002);
		send_rect(-5, -5, 40, 40, 0, 0, 16'hffff);
		send_rect(100, 100, 110, 110, 16'h7fff, 16'h8000, 16'h0000);
		send_rect(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'haaaa);
		send_rect(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 16'h0000, 16'h5555);
		send_rect(5, 5, 5, 5, 1, 1, 16'h0003);
		send_rect(16'h8000, 0, 16'h7ff0, 10, 16'h7ff0, 16'h7ff0, 16'h0004);
		send_rect(16'h8010, 0, 16'h7fff, 20, 16'h7ff0, 16'h7ff0, 16'h0005);
		// Build up to overflow with a checkerboard, then cover it.
		for (int i = 0; i < 12; i++)
			send_rect(16'(i * 4), 16'd0, 16'(i * 4 + 3), 16'd50, 16'(i), 16'(i), 16'(i));
		send_rect(1, 10, 60, 12, 0, 0, 16'h00ee);
		send_rect(2, 20, 60, 22, 0, 0, 16'h00ef);
		send_rect(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 0, 0, 16'h0000);

		// Disabled, then random with a few enable changes.
		set_enable(1'b0);
		send_rect(1, 2, 3, 4, 5, 6, 16'h0007);
		send_random();
		set_enable(1'b1);
		for (int i = 0; i < 140; i++) begin
			if (i == 50 || i == 90) begin
				set_enable(1'b0);
				repeat (3) send_random();
				set_enable(1'b1);
			end
			if (i == 115)
				calm_phase = 1'b1;
			send_random();
		end
		in_valid <= 1'b0;

		while (pending_entries != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
